[rtl/lcwf_pkg.sv]
// Shared types, constants and command/status structs of the low cost window finder.
package lcwf_pkg;

  localparam int MaxDuration  = 64;
  localparam int RingBits     = 6;
  localparam int NumSources   = 6;
  localparam int NumBits      = 39;
  localparam int DenBits      = 19;
  localparam int TotalBits    = 22;
  localparam int SumBits      = 23;
  localparam int DivSteps     = 24;
  localparam int DivCntBits   = 5;

  localparam logic [2:0] RegCostA   = 3'd0;
  localparam logic [2:0] RegCostB   = 3'd1;
  localparam logic [2:0] RegMaxAvg  = 3'd2;
  localparam logic [2:0] RegDur     = 3'd3;
  localparam logic [2:0] RegPStart  = 3'd4;
  localparam logic [2:0] RegPEnd    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_CHECK,
    ST_SUM,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mac_step;
    logic div_start;
    logic div_step;
    logic check;
    logic sum_start;
    logic sum_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mac_done;
    logic div_done;
    logic emit;
    logic sum_done;
  } status_t;

  // Input item.
  typedef struct packed {
    logic [7:0]         region_id;
    logic               first_of_series;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour_of_day;
    logic [15:0]        thermal_mw;
    logic [15:0]        nuclear_mw;
    logic [15:0]        wind_mw;
    logic [15:0]        solar_mw;
    logic [15:0]        hydro_mw;
    logic [15:0]        bio_mw;
    logic signed [15:0] balance_mw;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0]           solution_region;
    logic [3:0]           start_month;
    logic [4:0]           start_day;
    logic [4:0]           start_hour;
    logic [3:0]           end_month;
    logic [4:0]           end_day;
    logic [4:0]           end_hour;
    logic [TotalBits-1:0] total_cost;
  } out_item_t;

  // Configuration write.
  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_item_t;

endpackage

[rtl/lcwf_if.sv]
// Valid/ready channel interfaces of the low cost window finder.
interface lcwf_in_if import lcwf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lcwf_out_if import lcwf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lcwf_cfg_if import lcwf_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/low_cost_window_finder_unit.sv]
// Top level of the low cost window finder.
// Takes one hourly record at a time: a multiply-accumulate over the six sources,
// a restoring divider for the weighted average and a qualification step; a
// record that completes a window adds ring reads for the window sum and
// waits in the result register until taken. Configuration is taken at any time.
module low_cost_window_finder_unit import lcwf_pkg::*; (
  input logic clk,
  input logic rst,
  lcwf_in_if.sink    in_ch,
  lcwf_out_if.source out_ch,
  lcwf_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t sts;

  assign cfg.ready = 1'b1;

  lcwf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcwf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_ch.data),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.data),
    .out_data (out_ch.data)
  );

endmodule

[rtl/lcwf_ctrl.sv]
// Controller state machine of the low cost window finder.
module lcwf_ctrl import lcwf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MAC;
      ST_MAC:   if (sts.mac_done) state_next = ST_DIV;
      ST_DIV:   if (sts.div_done) state_next = ST_CHECK;
      ST_CHECK: state_next = sts.emit ? ST_SUM : ST_IDLE;
      ST_SUM:   if (sts.sum_done) state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MAC: begin
        cmd.mac_step  = 1'b1;
        cmd.div_start = sts.mac_done;
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_CHECK: begin
        cmd.check     = 1'b1;
        cmd.sum_start = sts.emit;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        cmd.out_load = sts.sum_done;
      end
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

[rtl/lcwf_datapath.sv]
// Datapath of the low cost window finder: cost accumulator, divider, run rings and window sum.
module lcwf_datapath import lcwf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  output status_t   sts,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  cfg_item_t cfg_data,
  output out_item_t out_data
);

  // Configuration registers.
  logic [63:0] cost_word_a;
  logic [31:0] cost_word_b;
  logic [15:0] max_avg_cost;
  logic [6:0]  duration;
  logic [13:0] period_start;
  logic [13:0] period_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_word_a  <= '0;
      cost_word_b  <= '0;
      max_avg_cost <= 16'hFFFF;
      duration     <= 7'd1;
      period_start <= '0;
      period_end   <= 14'h3FFF;
    end else if (cfg_we) begin
      unique case (cfg_data.index)
        RegCostA:  cost_word_a  <= cfg_data.data;
        RegCostB:  cost_word_b  <= cfg_data.data[31:0];
        RegMaxAvg: max_avg_cost <= cfg_data.data[15:0];
        RegDur:    duration     <= cfg_data.data[6:0];
        RegPStart: period_start <= cfg_data.data[13:0];
        RegPEnd:   period_end   <= cfg_data.data[13:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  in_item_t item;
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
  end

  logic [13:0] now;
  assign now = {item.month, item.day, item.hour_of_day};

  // Multiply-accumulate over the six sources, one per cycle.
  logic [2:0]         src;
  logic [NumBits-1:0] num;
  logic [NumBits-1:0] num_next;
  logic [DenBits-1:0] den;
  logic [15:0]        p_sel, c_sel;
  logic [31:0]        prod;

  always_comb begin
    unique case (src)
      3'd0:    begin p_sel = item.thermal_mw; c_sel = cost_word_a[15:0];  end
      3'd1:    begin p_sel = item.nuclear_mw; c_sel = cost_word_a[31:16]; end
      3'd2:    begin p_sel = item.wind_mw;    c_sel = cost_word_a[47:32]; end
      3'd3:    begin p_sel = item.solar_mw;   c_sel = cost_word_a[63:48]; end
      3'd4:    begin p_sel = item.hydro_mw;   c_sel = cost_word_b[15:0];  end
      default: begin p_sel = item.bio_mw;     c_sel = cost_word_b[31:16]; end
    endcase
  end
  assign prod     = p_sel * c_sel;
  assign num_next = num + NumBits'(prod);
  assign sts.mac_done = (src == 3'(NumSources - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      src <= '0;
    end else if (cmd.load) begin
      src <= '0;
    end else if (cmd.mac_step) begin
      src <= sts.mac_done ? 3'd0 : src + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= '0;
      den <= '0;
    end else if (cmd.mac_step) begin
      num <= num_next;
      den <= den + DenBits'(p_sel);
    end
  end

  // Restoring divider; the quotient never exceeds 16 bits, so 24 steps over
  // the top bits suffice once the shift starts 24 bits down.
  logic [NumBits-1:0]    quo;
  logic [DenBits:0]      rem;
  logic [DivCntBits-1:0] div_cnt;
  logic [DenBits:0]      rem_sh;
  logic [DenBits+1:0]    trial;

  assign rem_sh = {rem[DenBits-1:0], quo[NumBits-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      // The divider starts on the sum that includes the last source.
      rem     <= {5'b0, num_next[NumBits-1:DivSteps]};
      quo     <= {num_next[DivSteps-1:0], 15'b0};
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[DenBits+1]) rem <= trial[DenBits:0];
      else rem <= rem_sh;
      quo     <= {quo[NumBits-2:0], ~trial[DenBits+1]};
      div_cnt <= div_cnt + 1'b1;
    end
  end
  assign sts.div_done = (div_cnt == DivCntBits'(DivSteps - 1));

  logic [15:0] avg;
  assign avg = quo[15:0];

  // Qualification and run tracking.
  logic [7:0]          current_region;
  logic [6:0]          run_length;
  logic [RingBits-1:0] ring_pointer;
  logic [6:0]          dur_eff;
  logic                new_series, ok, bal_pos;
  logic [6:0]          run_next;

  assign new_series = item.first_of_series || (item.region_id != current_region);
  assign bal_pos    = !item.balance_mw[15] && (item.balance_mw != 16'sd0);
  assign ok = (den != '0) && (now >= period_start) && (now <= period_end) &&
              !bal_pos && ({8'b0, avg[15:0]} <= {8'b0, max_avg_cost});
  always_comb begin
    if (duration == 7'd0) dur_eff = 7'd1;
    else if (duration > 7'(MaxDuration)) dur_eff = 7'(MaxDuration);
    else dur_eff = duration;
  end
  always_comb begin
    run_next = new_series ? 7'd0 : run_length;
    if (run_next < 7'(MaxDuration)) run_next = run_next + 7'd1;
  end
  assign sts.emit = ok && (run_next >= dur_eff);

  // Rings of hourly costs and start times.
  logic [15:0] hour_cost_ring [MaxDuration];
  logic [13:0] start_time_ring [MaxDuration];

  always_ff @(posedge clk) begin
    if (cmd.check && ok) begin
      hour_cost_ring[ring_pointer]  <= avg;
      start_time_ring[ring_pointer] <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length     <= '0;
      ring_pointer   <= '0;
      current_region <= '0;
    end else if (cmd.check) begin
      current_region <= item.region_id;
      if (ok) begin
        run_length   <= run_next;
        ring_pointer <= ring_pointer + 1'b1;
      end else begin
        run_length <= '0;
      end
    end
  end

  // Window sum, one ring entry per cycle with registered reads.
  logic [RingBits-1:0] rd_idx, start_idx;
  logic [6:0]          sum_cnt;
  logic [15:0]         rd_cost;
  logic [13:0]         rd_start;
  logic                rd_valid;
  logic [SumBits-1:0]  window_cost_sum;

  // The start time is read in the first summing cycle, after the current hour
  // has been written, so a one-hour window sees its own entry.
  always_ff @(posedge clk) begin
    rd_cost <= hour_cost_ring[rd_idx];
    if (cmd.sum_step && (sum_cnt == dur_eff)) rd_start <= start_time_ring[rd_idx];
  end
  // Oldest entry of the window, counted from the pointer after this hour's write.
  assign start_idx = ring_pointer + 1'b1 - RingBits'(dur_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.sum_step && (sum_cnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      rd_idx          <= start_idx;
      sum_cnt         <= dur_eff;
      window_cost_sum <= '0;
    end else if (cmd.sum_step) begin
      if (sum_cnt != '0) begin
        rd_idx  <= rd_idx + 1'b1;
        sum_cnt <= sum_cnt - 7'd1;
      end
      if (rd_valid) window_cost_sum <= window_cost_sum + SumBits'(rd_cost);
    end
  end
  assign sts.sum_done = (sum_cnt == '0) && !rd_valid;

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.solution_region <= current_region;
      out_data.start_month     <= rd_start[13:10];
      out_data.start_day       <= rd_start[9:5];
      out_data.start_hour      <= rd_start[4:0];
      out_data.end_month       <= item.month;
      out_data.end_day         <= item.day;
      out_data.end_hour        <= item.hour_of_day;
      out_data.total_cost      <= window_cost_sum[SumBits-1] ?
                                  {TotalBits{1'b1}} : window_cost_sum[TotalBits-1:0];
    end
  end

endmodule
